FILE: hdl/swc_pkg.sv
// ----------------------------------------------------------------------------
// swc_pkg
// Shared types and constants for the sliding window centroid block.
// ----------------------------------------------------------------------------
`default_nettype none

package swc_pkg;

  localparam int SAMPLE_W        = 20;
  localparam int VAL_W           = 19;
  localparam int IDX_OUT_W       = 9;
  localparam int FRAC_W          = 14;
  localparam int FRAC_SCALE      = 10000;
  localparam int INT_LIM_RST     = 2;
  localparam int FRAC_LIM_RST    = 2000;
  localparam int WINDOW_DEF      = 17;
  localparam int LINE_LENGTH_DEF = 512;

  // APB register map
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_INT_LIM  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_FRAC_LIM = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       line_start;
  } in_item_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] window_first;
    logic [IDX_OUT_W-1:0] centroid_int;
    logic [FRAC_W-1:0]    centroid_frac;
    logic [IDX_OUT_W-1:0] center_int;
    logic [FRAC_W-1:0]    center_frac;
    logic                 stable;
    logic                 empty_window;
  } out_item_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] int_lim;
    logic [FRAC_W-1:0]    frac_lim;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_CHECK,
    ST_DIV_INT,
    ST_SAVE_INT,
    ST_LOAD_FRAC,
    ST_DIV_FRAC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic take;
    logic mult;
    logic accum;
    logic div_load_int;
    logic div_step;
    logic div_save_int;
    logic div_load_frac;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

FILE: hdl/swc_stream_if.sv
// ----------------------------------------------------------------------------
// swc_stream_if
// Valid/ready stream channel carrying one payload beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface swc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/swc_cfg.sv
// ----------------------------------------------------------------------------
// swc_cfg
// APB register file holding the two stability limits.
// ----------------------------------------------------------------------------
`default_nettype none

module swc_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [swc_pkg::APB_AW-1:0]   paddr,
  input  wire logic [swc_pkg::APB_DW-1:0]   pwdata,
  output logic      [swc_pkg::APB_DW-1:0]   prdata,
  output logic                              pready,
  output swc_pkg::cfg_t                     cfg
);

  logic [swc_pkg::IDX_OUT_W-1:0] int_lim_r;
  logic [swc_pkg::FRAC_W-1:0]    frac_lim_r;
  logic [swc_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[swc_pkg::APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_lim_r  <= swc_pkg::IDX_OUT_W'(swc_pkg::INT_LIM_RST);
      frac_lim_r <= swc_pkg::FRAC_W'(swc_pkg::FRAC_LIM_RST);
    end else if (wr_en) begin
      case (reg_idx)
        swc_pkg::REG_INT_LIM:  int_lim_r  <= pwdata[swc_pkg::IDX_OUT_W-1:0];
        swc_pkg::REG_FRAC_LIM: frac_lim_r <= pwdata[swc_pkg::FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      swc_pkg::REG_INT_LIM:  prdata = swc_pkg::APB_DW'(int_lim_r);
      swc_pkg::REG_FRAC_LIM: prdata = swc_pkg::APB_DW'(frac_lim_r);
      default:               prdata = '0;
    endcase
  end

  assign cfg.int_lim  = int_lim_r;
  assign cfg.frac_lim = frac_lim_r;

endmodule

`default_nettype wire

FILE: hdl/swc_ctrl.sv
// ----------------------------------------------------------------------------
// swc_ctrl
// Sequencer: update sums, run the two bit-serial division passes, emit.
// ----------------------------------------------------------------------------
`default_nettype none

module swc_ctrl #(
  parameter int LINE_LENGTH = swc_pkg::LINE_LENGTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire swc_pkg::stat_t stat,
  output swc_pkg::cmd_t      cmd
);

  localparam int Q1_W  = $clog2(LINE_LENGTH);
  localparam int CNT_W = $clog2(swc_pkg::FRAC_W);

  swc_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             int_last, frac_last;

  assign int_last  = (cnt_r == CNT_W'(Q1_W - 1));
  assign frac_last = (cnt_r == CNT_W'(swc_pkg::FRAC_W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swc_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swc_pkg::ST_IDLE:      if (in_valid) state_nxt = swc_pkg::ST_MUL;
      swc_pkg::ST_MUL:       state_nxt = swc_pkg::ST_ACC;
      swc_pkg::ST_ACC:       state_nxt = swc_pkg::ST_CHECK;
      swc_pkg::ST_CHECK: begin
        if (!stat.full) begin
          state_nxt = swc_pkg::ST_IDLE;
        end else if (stat.empty) begin
          state_nxt = swc_pkg::ST_EMIT;
        end else begin
          state_nxt = swc_pkg::ST_DIV_INT;
        end
      end
      swc_pkg::ST_DIV_INT:   if (int_last) state_nxt = swc_pkg::ST_SAVE_INT;
      swc_pkg::ST_SAVE_INT:  state_nxt = swc_pkg::ST_LOAD_FRAC;
      swc_pkg::ST_LOAD_FRAC: state_nxt = swc_pkg::ST_DIV_FRAC;
      swc_pkg::ST_DIV_FRAC:  if (frac_last) state_nxt = swc_pkg::ST_EMIT;
      swc_pkg::ST_EMIT:      if (stat.out_free) state_nxt = swc_pkg::ST_IDLE;
      default:               state_nxt = swc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    cnt_nxt  = '0;
    case (state_r)
      swc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      swc_pkg::ST_MUL:   cmd.mult  = 1'b1;
      swc_pkg::ST_ACC:   cmd.accum = 1'b1;
      swc_pkg::ST_CHECK: cmd.div_load_int = stat.full && !stat.empty;
      swc_pkg::ST_DIV_INT: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = int_last ? '0 : cnt_r + 1'b1;
      end
      swc_pkg::ST_SAVE_INT:  cmd.div_save_int  = 1'b1;
      swc_pkg::ST_LOAD_FRAC: cmd.div_load_frac = 1'b1;
      swc_pkg::ST_DIV_FRAC: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = frac_last ? '0 : cnt_r + 1'b1;
      end
      swc_pkg::ST_EMIT:  cmd.emit = stat.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/swc_dp.sv
// ----------------------------------------------------------------------------
// swc_dp
// Datapath: pixel ring, running sums, restoring divider, stability check
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module swc_dp #(
  parameter int WINDOW      = swc_pkg::WINDOW_DEF,
  parameter int LINE_LENGTH = swc_pkg::LINE_LENGTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire swc_pkg::cmd_t       cmd,
  output swc_pkg::stat_t           stat,
  input  wire swc_pkg::cfg_t       cfg,
  input  wire swc_pkg::in_item_t   in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output swc_pkg::out_item_t       out_item
);

  localparam int VAL_W  = swc_pkg::VAL_W;
  localparam int FRAC_W = swc_pkg::FRAC_W;
  localparam int OUT_W  = swc_pkg::IDX_OUT_W;
  localparam int IDX_W  = $clog2(LINE_LENGTH + 1);
  localparam int Q1_W   = $clog2(LINE_LENGTH);
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int PSUM_W = VAL_W + SLOT_W;
  localparam int WSUM_W = PSUM_W + Q1_W;
  localparam int PN_W   = VAL_W + Q1_W;
  localparam int RM_W   = PSUM_W + FRAC_W;
  localparam int QX_W   = ((Q1_W > OUT_W) ? Q1_W : OUT_W) + 1;

  // ring of the last WINDOW pixel values
  logic [VAL_W-1:0] ring_mem [WINDOW];
  logic [VAL_W-1:0] old_r;

  logic [IDX_W-1:0]  pix_r;
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] cur_slot_r;
  logic [Q1_W-1:0]   cur_i_r;
  logic [VAL_W-1:0]  v_r;
  logic              has_old_r, full_r;
  logic [PSUM_W-1:0] psum_r;
  logic [WSUM_W-1:0] wsum_r;
  logic [WSUM_W-1:0] prod_new_r, prod_old_r;

  logic [PSUM_W-1:0] rem_r;
  logic [FRAC_W-1:0] dvdq_r;
  logic [Q1_W-1:0]   q_r;
  logic [RM_W-1:0]   rmul_r;

  logic [OUT_W-1:0]  prev_int_r;
  logic [FRAC_W-1:0] prev_frac_r;
  logic              prev_valid_r;

  logic               out_valid_r;
  swc_pkg::out_item_t out_r;
  swc_pkg::out_item_t out_nxt;

  // take-time decode
  logic              line_clr;
  logic [IDX_W-1:0]  cur_i;
  logic [SLOT_W-1:0] cur_slot;
  logic [VAL_W-1:0]  v_in;

  assign line_clr = in_item.line_start || (pix_r >= IDX_W'(LINE_LENGTH));
  assign cur_i    = line_clr ? '0 : pix_r;
  assign cur_slot = line_clr ? '0 : slot_r;
  assign v_in     = in_item.sample[swc_pkg::SAMPLE_W-1] ? '0 : in_item.sample[VAL_W-1:0];

  // products
  logic [PN_W-1:0] pn, po;
  logic [Q1_W-1:0] old_idx;

  assign old_idx = cur_i_r - Q1_W'(WINDOW);
  assign pn      = v_r * cur_i_r;
  assign po      = old_r * old_idx;

  // one restoring division step
  logic [PSUM_W:0] shifted, diff;
  logic            ge;

  assign shifted = {rem_r, dvdq_r[FRAC_W-1]};
  assign ge      = (shifted >= {1'b0, psum_r});
  assign diff    = shifted - {1'b0, psum_r};

  // stability and center
  logic signed [QX_W:0] q_x, pi_x, dint, lim_x;
  logic [FRAC_W-1:0]    frac, dfrac;
  logic                 stab;
  logic [QX_W-1:0]      isum;
  logic [FRAC_W:0]      fsum;
  logic [OUT_W-1:0]     first;

  assign frac  = dvdq_r;
  assign q_x   = signed'({{(QX_W + 1 - Q1_W){1'b0}}, q_r});
  assign pi_x  = signed'({{(QX_W + 1 - OUT_W){1'b0}}, prev_int_r});
  assign lim_x = signed'({{(QX_W + 1 - OUT_W){1'b0}}, cfg.int_lim});
  assign dint  = q_x - pi_x;
  assign dfrac = (frac >= prev_frac_r) ? frac - prev_frac_r : prev_frac_r - frac;
  assign stab  = prev_valid_r && (dint < lim_x) && (dfrac < cfg.frac_lim);
  assign isum  = q_x[QX_W-1:0] + pi_x[QX_W-1:0];
  assign fsum  = {1'b0, frac} + {1'b0, prev_frac_r};
  assign first = OUT_W'(32'(cur_i_r) - 32'(WINDOW - 1));

  // result beat assembled for the emit cycle
  always_comb begin
    out_nxt              = '0;
    out_nxt.window_first = first;
    if (psum_r == '0) begin
      out_nxt.empty_window = 1'b1;
    end else begin
      out_nxt.centroid_int  = q_x[OUT_W-1:0];
      out_nxt.centroid_frac = frac;
      if (stab) begin
        out_nxt.center_int  = isum[OUT_W:1];
        out_nxt.center_frac = fsum[FRAC_W:1];
        out_nxt.stable      = 1'b1;
      end
    end
  end

  // ring memory
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      old_r <= ring_mem[cur_slot];
    end
    if (cmd.accum) begin
      ring_mem[cur_slot_r] <= v_r;
    end
  end

  // control-like state: indices, sums, history, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r        <= '0;
      slot_r       <= '0;
      psum_r       <= '0;
      wsum_r       <= '0;
      prev_int_r   <= '0;
      prev_frac_r  <= '0;
      prev_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.take) begin
        pix_r  <= cur_i + 1'b1;
        slot_r <= (cur_slot == SLOT_W'(WINDOW - 1)) ? '0 : cur_slot + 1'b1;
        if (line_clr) begin
          psum_r       <= '0;
          wsum_r       <= '0;
          prev_valid_r <= 1'b0;
        end
      end
      if (cmd.accum) begin
        psum_r <= psum_r + PSUM_W'(v_r) - (has_old_r ? PSUM_W'(old_r) : '0);
        wsum_r <= wsum_r + prod_new_r - prod_old_r;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        if (psum_r == '0) begin
          prev_valid_r <= 1'b0;
        end else begin
          prev_int_r   <= q_x[OUT_W-1:0];
          prev_frac_r  <= frac;
          prev_valid_r <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      v_r        <= v_in;
      cur_i_r    <= cur_i[Q1_W-1:0];
      cur_slot_r <= cur_slot;
      has_old_r  <= (cur_i >= IDX_W'(WINDOW));
      full_r     <= (cur_i >= IDX_W'(WINDOW - 1));
    end
    if (cmd.mult) begin
      prod_new_r <= WSUM_W'(pn);
      prod_old_r <= has_old_r ? WSUM_W'(po) : '0;
    end
    if (cmd.div_load_int) begin
      rem_r  <= wsum_r[WSUM_W-1:Q1_W];
      dvdq_r <= {wsum_r[Q1_W-1:0], {(FRAC_W - Q1_W){1'b0}}};
    end else if (cmd.div_load_frac) begin
      rem_r  <= rmul_r[RM_W-1:FRAC_W];
      dvdq_r <= rmul_r[FRAC_W-1:0];
    end else if (cmd.div_step) begin
      rem_r  <= ge ? diff[PSUM_W-1:0] : shifted[PSUM_W-1:0];
      dvdq_r <= {dvdq_r[FRAC_W-2:0], ge};
    end
    if (cmd.div_save_int) begin
      q_r    <= dvdq_r[Q1_W-1:0];
      rmul_r <= rem_r * FRAC_W'(swc_pkg::FRAC_SCALE);
    end
    if (cmd.emit) begin
      out_r <= out_nxt;
    end
  end

  assign stat.full     = full_r;
  assign stat.empty    = (psum_r == '0);
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

FILE: hdl/sliding_window_centroid_peak.sv
// ----------------------------------------------------------------------------
// sliding_window_centroid_peak
// Sliding-window centroid of a line-sensor signal with stability check.
// ----------------------------------------------------------------------------
// Each pixel is taken in idle and runs MUL, ACC and CHECK; a filling pixel
//   then returns to idle and an empty window goes straight to EMIT.
// A full window runs the two bit-serial division passes ($clog2(LINE_LENGTH) and
//   14 steps of one restoring divider) and then EMIT. A result register lets
//   the next pixel in while it waits.
// Reset (rst_n, synchronous): clears sums, line position and history; the
//   limits return to 2 and 2000.
`default_nettype none

module sliding_window_centroid_peak #(
  parameter int WINDOW      = swc_pkg::WINDOW_DEF,
  parameter int LINE_LENGTH = swc_pkg::LINE_LENGTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  swc_stream_if.sink                       in_ch,
  swc_stream_if.source                     out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [swc_pkg::APB_AW-1:0]  paddr,
  input  wire logic [swc_pkg::APB_DW-1:0]  pwdata,
  output logic      [swc_pkg::APB_DW-1:0]  prdata,
  output logic                             pready
);

  swc_pkg::cfg_t      cfg;
  swc_pkg::cmd_t      cmd;
  swc_pkg::stat_t     stat;
  swc_pkg::out_item_t out_item;
  logic               in_ready;
  logic               out_valid;

  swc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  swc_ctrl #(
    .LINE_LENGTH (LINE_LENGTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  swc_dp #(
    .WINDOW      (WINDOW),
    .LINE_LENGTH (LINE_LENGTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg       (cfg),
    .in_item   (in_ch.data),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_item;

endmodule

`default_nettype wire

FILE: dv/sliding_window_centroid_peak_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_centroid_peak_tb
// Self-checking bench for the sliding-window centroid block: pixels go in as
// lines of shaped or random signal, a cycle-free predictor in this file works
// out each window's centroid and stability, and every result beat is compared
// field by field. Limits are changed between phases over the APB port.
// ----------------------------------------------------------------------------

module sliding_window_centroid_peak_tb;

  localparam int          WIN           = swc_pkg::WINDOW_DEF;
  localparam int          LINE_LEN      = swc_pkg::LINE_LENGTH_DEF;
  localparam int          SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT   = 1200000;
  localparam int          MAX_REPORTS   = 100;

  typedef enum int {SIG_PEAK, SIG_FLAT, SIG_DARK, SIG_NOISE, SIG_SPARSE} sig_kind_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [swc_pkg::APB_AW-1:0] paddr;
  logic [swc_pkg::APB_DW-1:0] pwdata;
  logic [swc_pkg::APB_DW-1:0] prdata;
  logic pready;

  swc_stream_if #(.payload_t(swc_pkg::in_item_t))  in_ch ();
  swc_stream_if #(.payload_t(swc_pkg::out_item_t)) out_ch ();

  sliding_window_centroid_peak dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [swc_pkg::VAL_W-1:0]     px_ring [WIN];
  longint unsigned               win_wsum;
  longint unsigned               win_sum;
  int unsigned                   line_pos;
  logic [swc_pkg::IDX_OUT_W-1:0] last_int;
  logic [swc_pkg::FRAC_W-1:0]    last_frac;
  bit                            last_ok;
  logic [swc_pkg::IDX_OUT_W-1:0] lim_int  = swc_pkg::IDX_OUT_W'(swc_pkg::INT_LIM_RST);
  logic [swc_pkg::FRAC_W-1:0]    lim_frac = swc_pkg::FRAC_W'(swc_pkg::FRAC_LIM_RST);

  swc_pkg::out_item_t expected_centroids [$];
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned pixels_sent  = 0;
  int unsigned stall_hold   = 0;
  bit          no_idle      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("sliding_window_centroid_peak: mismatch");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                results_seen, name, got, want));
    end
  endtask

  function automatic void clear_line();
    foreach (px_ring[i]) px_ring[i] = '0;
    win_wsum = 0;
    win_sum  = 0;
    line_pos = 0;
    last_ok  = 1'b0;
  endfunction

  // Returns 1 and the expected beat when this pixel completes a window.
  function automatic bit predict_centroid(input swc_pkg::in_item_t px,
                                          output swc_pkg::out_item_t res);
    int unsigned     v;
    int unsigned     slot;
    longint unsigned old;
    longint unsigned q;
    longint unsigned r;
    longint unsigned fr;
    longint          dint;
    longint          dfrac;
    bit              stab;
    res = '0;
    v = px.sample[swc_pkg::SAMPLE_W-1] ? 0 : px.sample[swc_pkg::VAL_W-1:0];
    if (px.line_start || line_pos >= LINE_LEN) clear_line();
    slot = line_pos % WIN;
    if (line_pos >= WIN) begin
      old = px_ring[slot];
      win_sum  -= old;
      win_wsum -= old * 64'(line_pos - WIN);
    end
    px_ring[slot] = v[swc_pkg::VAL_W-1:0];
    win_sum  += 64'(v);
    win_wsum += 64'(v) * 64'(line_pos);
    line_pos++;
    if (line_pos < WIN) return 1'b0;

    res.window_first = swc_pkg::IDX_OUT_W'(line_pos - WIN);
    if (win_sum == 0) begin
      res.empty_window = 1'b1;
      last_ok = 1'b0;
      return 1'b1;
    end
    q  = win_wsum / win_sum;
    r  = win_wsum % win_sum;
    fr = (r * swc_pkg::FRAC_SCALE) / win_sum;
    stab = 1'b0;
    if (last_ok) begin
      dint  = longint'(q) - longint'(last_int);
      dfrac = longint'(fr) - longint'(last_frac);
      if (dfrac < 0) dfrac = -dfrac;
      stab = (dint < longint'(lim_int)) && (dfrac < longint'(lim_frac));
    end
    res.centroid_int  = q[swc_pkg::IDX_OUT_W-1:0];
    res.centroid_frac = fr[swc_pkg::FRAC_W-1:0];
    if (stab) begin
      res.center_int  = swc_pkg::IDX_OUT_W'((q + last_int) / 2);
      res.center_frac = swc_pkg::FRAC_W'((fr + last_frac) / 2);
      res.stable      = 1'b1;
    end
    last_int  = q[swc_pkg::IDX_OUT_W-1:0];
    last_frac = fr[swc_pkg::FRAC_W-1:0];
    last_ok   = 1'b1;
    return 1'b1;
  endfunction

  // Result check first, then prediction of the pixel taken at this edge.
  always @(posedge clk) begin : scoreboard
    swc_pkg::out_item_t got;
    swc_pkg::out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_centroids.size() == 0) begin
        report_mismatch("result beat with no pixel pending");
      end else begin
        want = expected_centroids.pop_front();
        got  = out_ch.data;
        check_field("window_first", got.window_first, want.window_first);
        check_field("centroid_int", got.centroid_int, want.centroid_int);
        check_field("centroid_frac", got.centroid_frac, want.centroid_frac);
        check_field("center_int", got.center_int, want.center_int);
        check_field("center_frac", got.center_frac, want.center_frac);
        check_field("stable", got.stable, want.stable);
        check_field("empty_window", got.empty_window, want.empty_window);
      end
      results_seen++;
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      if (predict_centroid(in_ch.data, want)) expected_centroids.push_back(want);
    end
  end

  // mostly short idles, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 16);
    return $urandom_range(20, 60);
  endfunction

  function automatic int sender_gap();
    if (no_idle || $urandom_range(0, 99) < 55) return 0;
    return idle_len();
  endfunction

  // result side: runs of ready and stalls; stall_hold forces a long hold-off
  initial begin : result_sink
    int unsigned run;
    bit          lvl;
    out_ch.ready = 1'b0;
    run = 0;
    lvl = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_hold > 0) begin
        out_ch.ready <= 1'b0;
        stall_hold--;
      end else if (no_idle) begin
        out_ch.ready <= 1'b1;
      end else begin
        if (run == 0) begin
          if ($urandom_range(0, 2) != 0) begin
            lvl = 1'b1;
            run = $urandom_range(1, 40);
          end else begin
            lvl = 1'b0;
            run = idle_len();
          end
        end
        run--;
        out_ch.ready <= lvl;
      end
    end
  end

  // called and returns at a falling edge
  task automatic send_pixel(input logic signed [swc_pkg::SAMPLE_W-1:0] s, input logic ls);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{sample: s, line_start: ls};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    pixels_sent++;
  endtask

  task automatic send_line(input int len, input sig_kind_t kind, input bit with_start);
    int c;
    int w;
    int amp;
    int lvl;
    int d;
    int s;
    int r;
    c   = $urandom_range(0, len);
    w   = $urandom_range(2, 24);
    amp = 524287 / w;
    lvl = $urandom_range(0, 524287);
    for (int p = 0; p < len; p++) begin
      case (kind)
        SIG_PEAK: begin
          d = (p > c) ? p - c : c - p;
          s = (d < w) ? amp * (w - d) : 0;
          s = s + int'($urandom_range(0, 255)) - 128;
        end
        SIG_FLAT: begin
          s = lvl + int'($urandom_range(0, 15));
        end
        SIG_DARK: begin
          r = $urandom_range(0, 19);
          if (r == 0)      s = $urandom_range(1, 1000);
          else if (r == 1) s = -int'($urandom_range(1, 524288));
          else             s = 0;
        end
        SIG_NOISE: begin
          s = int'($urandom_range(0, 20'hFFFFF));
        end
        default: begin
          s = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 524287)) : 0;
        end
      endcase
      if (kind != SIG_NOISE && s > 524287) s = 524287;
      send_pixel(swc_pkg::SAMPLE_W'(s), with_start && p == 0);
    end
  endtask

  // wait out every pending result, then the tail of a filling pixel
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_centroids.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // one setup + access pair; leaves psel high for the caller to close
  task automatic apb_cycle(input logic wr, input logic [swc_pkg::REG_IDX_W-1:0] idx,
                           input logic [swc_pkg::APB_DW-1:0] wdata,
                           output logic [swc_pkg::APB_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [swc_pkg::REG_IDX_W-1:0] idx,
                           input logic [swc_pkg::APB_DW-1:0] val);
    logic [swc_pkg::APB_DW-1:0] rd;
    logic [swc_pkg::APB_DW-1:0] want;
    apb_cycle(1'b1, idx, val, rd);
    if (idx == swc_pkg::REG_INT_LIM) begin
      lim_int = val[swc_pkg::IDX_OUT_W-1:0];
      want    = swc_pkg::APB_DW'(lim_int);
    end else begin
      lim_frac = val[swc_pkg::FRAC_W-1:0];
      want     = swc_pkg::APB_DW'(lim_frac);
    end
    apb_cycle(1'b0, idx, '0, rd);
    if (rd !== want) begin
      report_mismatch($sformatf("register %0d readback 0x%0h, expected 0x%0h",
                                idx, rd, want));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_limits(input logic [swc_pkg::APB_DW-1:0] int_val,
                            input logic [swc_pkg::APB_DW-1:0] frac_val);
    drain();
    write_reg(swc_pkg::REG_INT_LIM, int_val);
    write_reg(swc_pkg::REG_FRAC_LIM, frac_val);
  endtask

  // clipped negatives, empty window, first centroid, stable steps, restarts
  task automatic test_directed();
    logic signed [swc_pkg::SAMPLE_W-1:0] s;
    for (int p = 0; p < 17; p++) begin
      s = (p == 0) ? 20'h80000 : (p == 5) ? 20'hFFFFF : 20'h00000;
      send_pixel(s, p == 0);
    end
    send_pixel(20'h7FFFF, 1'b0);
    send_pixel(20'h00000, 1'b0);
    send_pixel(20'h00000, 1'b0);
    send_pixel(20'h00001, 1'b0);
    send_pixel(20'h7FFFF, 1'b1);
    send_pixel(20'h12345, 1'b0);
    send_pixel(20'hFFFFF, 1'b1);
    send_pixel(20'h00007, 1'b0);
  endtask

  // line longer than LINE_LENGTH wraps into a new line on its own
  task automatic test_line_overrun();
    send_line(LINE_LEN + 28, SIG_FLAT, 1'b1);
  endtask

  task automatic test_random_lines(input logic [swc_pkg::APB_DW-1:0] int_val,
                                   input logic [swc_pkg::APB_DW-1:0] frac_val,
                                   input int count, input bit gapless);
    int unsigned start_cnt;
    int          len;
    int          r;
    sig_kind_t   kind;
    set_limits(int_val, frac_val);
    no_idle   = gapless;
    start_cnt = pixels_sent;
    while (pixels_sent - start_cnt < count) begin
      r = $urandom_range(0, 99);
      len = (r < 70) ? $urandom_range(17, 90) :
            (r < 85) ? $urandom_range(1, 16) : $urandom_range(91, 200);
      r = $urandom_range(0, 99);
      kind = (r < 40) ? SIG_PEAK : (r < 55) ? SIG_FLAT : (r < 70) ? SIG_DARK :
             (r < 85) ? SIG_NOISE : SIG_SPARSE;
      send_line(len, kind, $urandom_range(0, 6) != 0);
    end
    no_idle = 1'b0;
  endtask

  // receiver holds off long enough for the input side to back up
  task automatic test_backpressure();
    drain();
    stall_hold = 400;
    send_line(60, SIG_FLAT, 1'b1);
  endtask

  initial begin : main
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rst_n   = 1'b0;
    last_int  = '0;
    last_frac = '0;
    clear_line();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_line_overrun();
    test_random_lines(32'd0, 32'd0, 130, 1'b0);
    test_random_lines(32'hFFFF_FFFF, 32'hFFFF_FFFF, 130, 1'b0);
    test_random_lines(32'd1, 32'd9999, 130, 1'b1);
    test_random_lines($urandom_range(0, 511), $urandom_range(0, 9999), 130, 1'b0);
    test_random_lines($urandom_range(0, 511), $urandom_range(0, 9999), 130, 1'b0);
    test_random_lines(32'd2, 32'd2000, 130, 1'b0);
    test_backpressure();

    drain();
    if (mismatches == 0) begin
      $display("sliding_window_centroid_peak: match");
    end else begin
      $display("sliding_window_centroid_peak: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/swc_pkg.sv
hdl/swc_stream_if.sv
hdl/swc_cfg.sv
hdl/swc_ctrl.sv
hdl/swc_dp.sv
hdl/sliding_window_centroid_peak.sv
dv/sliding_window_centroid_peak_tb.sv
